// ----- hw/rtl/sss_pkg.sv -----
// shared types and constants of the stream substring scanner
// used by sss_cfg_regs, sss_match_core and stream_substring_scanner
`default_nettype none

package sss_pkg;

  // widths fixed by the register map and the word fields
  localparam int unsigned RegW     = 64;
  localparam int unsigned PatBytes = 32;
  localparam int unsigned LenW     = 6;
  localparam int unsigned CntW     = 32;
  localparam int unsigned CfgIdxW  = 3;

  // word operation codes
  typedef enum logic [0:0] {
    OP_DATA = 1'b0,
    OP_EOS  = 1'b1
  } op_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_PAT_LOW    = 3'd0,
    REG_PAT_SECOND = 3'd1,
    REG_PAT_THIRD  = 3'd2,
    REG_PAT_HIGH   = 3'd3,
    REG_PAT_LEN    = 3'd4,
    REG_OPT_MODE   = 3'd5
  } cfg_idx_e;

  // input word
  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
  } in_t;

  // result word
  typedef struct packed {
    logic            scan_done;
    logic            found;
    logic            success;
    logic [CntW-1:0] consumed_count;
  } out_t;

  // configuration as seen by the match core
  typedef struct packed {
    logic [PatBytes-1:0][7:0] pattern;
    logic [LenW-1:0]          length;
    logic                     optional_mode;
  } cfg_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sss_cfg_regs.sv -----
// configuration registers: pattern bytes, pattern length, optional mode
// depends on sss_pkg
`default_nettype none

module sss_cfg_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [sss_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [sss_pkg::RegW-1:0]    cfg_wdata_i,
  output sss_pkg::cfg_t                    cfg_o
);

  logic [3:0][sss_pkg::RegW-1:0] pat_q;
  logic [sss_pkg::LenW-1:0]      len_q;
  logic                          opt_q;

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q <= '0;
      len_q <= sss_pkg::LenW'(1);
      opt_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sss_pkg::REG_PAT_LOW:    pat_q[0] <= cfg_wdata_i;
        sss_pkg::REG_PAT_SECOND: pat_q[1] <= cfg_wdata_i;
        sss_pkg::REG_PAT_THIRD:  pat_q[2] <= cfg_wdata_i;
        sss_pkg::REG_PAT_HIGH:   pat_q[3] <= cfg_wdata_i;
        sss_pkg::REG_PAT_LEN:    len_q    <= cfg_wdata_i[sss_pkg::LenW-1:0];
        sss_pkg::REG_OPT_MODE:   opt_q    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // byte 0 sits in the low bits of the low register
  assign cfg_o.pattern       = pat_q;
  assign cfg_o.length        = len_q;
  assign cfg_o.optional_mode = opt_q;

endmodule

`default_nettype wire

// ----- hw/rtl/sss_match_core.sv -----
// shift-and match core: prefix vector, byte counter and result logic
// depends on sss_pkg
`default_nettype none

module sss_match_core #(
  parameter int unsigned MAX_PATTERN = 32
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   step_i,
  input  wire sss_pkg::in_t  item_i,
  input  wire sss_pkg::cfg_t cfg_i,
  output sss_pkg::out_t result_o
);

  localparam int unsigned IdxW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic [MAX_PATTERN-1:0]    act_q, act_d;
  logic [sss_pkg::CntW-1:0]  cnt_q, cnt_d, cnt_inc;
  logic [MAX_PATTERN-1:0]    eq;
  logic [MAX_PATTERN:0]      shifted_ext;
  logic [MAX_PATTERN-1:0]    next_act;
  logic [6:0]                len_ext, len_m1;
  logic                      hit;
  logic                      is_eos;

  // last pattern position in use, zero length counts as one
  assign len_ext = {1'b0, cfg_i.length};
  always_comb begin
    if (len_ext == 7'd0) begin
      len_m1 = 7'd0;
    end else if (len_ext > 7'(MAX_PATTERN)) begin
      len_m1 = 7'(MAX_PATTERN - 1);
    end else begin
      len_m1 = len_ext - 7'd1;
    end
  end

  // per-position byte compares, positions past the registers read as zero
  for (genvar gi = 0; gi < MAX_PATTERN; gi++) begin : g_cmp
    logic [7:0] pat_byte;
    if (gi < sss_pkg::PatBytes) begin : g_reg
      assign pat_byte = cfg_i.pattern[gi];
    end else begin : g_zero
      assign pat_byte = 8'h00;
    end
    assign eq[gi] = (pat_byte == item_i.data_byte) && (7'(gi) <= len_m1);
  end

  // shift in a fresh empty prefix and keep matching positions
  assign shifted_ext = {act_q, 1'b1};
  assign next_act    = shifted_ext[MAX_PATTERN-1:0] & eq;
  assign hit         = next_act[len_m1[IdxW-1:0]];
  assign is_eos      = (item_i.operation == sss_pkg::OP_EOS);

  // saturating byte count
  assign cnt_inc = (cnt_q == '1) ? cnt_q : cnt_q + sss_pkg::CntW'(1);

  // result word
  always_comb begin
    if (is_eos) begin
      result_o.scan_done      = 1'b1;
      result_o.found          = 1'b0;
      result_o.success        = cfg_i.optional_mode;
      result_o.consumed_count = cnt_q;
    end else begin
      result_o.scan_done      = hit;
      result_o.found          = hit;
      result_o.success        = hit;
      result_o.consumed_count = cnt_inc;
    end
  end

  // next scan state
  always_comb begin
    act_d = act_q;
    cnt_d = cnt_q;
    if (step_i) begin
      if (is_eos || hit) begin
        act_d = '0;
        cnt_d = '0;
      end else begin
        act_d = next_act;
        cnt_d = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= '0;
      cnt_q <= '0;
    end else begin
      act_q <= act_d;
      cnt_q <= cnt_d;
    end
  end

`ifndef NO_ASSERTIONS
  // a finished scan leaves a clean state behind
  a_clear_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && result_o.scan_done |=> (act_q == '0) && (cnt_q == '0))
    else $error("state not cleared after scan end");

  // end of stream never reports a match
  a_eos_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && is_eos |-> !result_o.found)
    else $error("end of stream reported found");

  // a data byte ends the scan only on a match
  a_data_done_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !is_eos |-> (result_o.scan_done == result_o.found))
    else $error("data byte done without match");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/stream_substring_scanner.sv -----
// stream substring scanner top level: input and result registers around the match core
// depends on sss_pkg, sss_cfg_regs and sss_match_core
//
//   port group   dir   handshake             payload
//   in_*         in    in_valid/in_ready     sss_pkg::in_t
//   out_*        out   out_valid/out_ready   sss_pkg::out_t
//   cfg_*        in    cfg_we (no wait)      index + 64-bit data
//
// one word per cycle while out_ready is high; results pass the input and output registers
// the prefix vector and byte counter update on each advance, closing the loop per word
// reset clears scan state, pattern bytes, optional mode, and sets length to one
// a stalled result holds in the output register while the input register still fills
`default_nettype none

module stream_substring_scanner #(
  parameter int unsigned MAX_PATTERN = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire sss_pkg::in_t                in_item_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output sss_pkg::out_t                    out_item_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [sss_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [sss_pkg::RegW-1:0]    cfg_wdata_i
);

  sss_pkg::in_t  in_q;
  logic          in_valid_q, in_valid_d;
  sss_pkg::out_t out_q, core_res;
  logic          out_valid_q, out_valid_d;
  logic          advance;
  logic          in_accept;
  sss_pkg::cfg_t cfg;

  // pipeline control
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_accept  = in_valid_i && in_ready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_item_i;
    end
    if (advance) begin
      out_q <= core_res;
    end
  end

  // configuration registers
  sss_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // matching logic and scan state
  sss_match_core #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (in_q),
    .cfg_i    (cfg),
    .result_o (core_res)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef NO_ASSERTIONS
  // an empty input register always takes a word
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> in_ready_o)
    else $error("input register empty but not ready");

  // a match always carries done and success
  a_found_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.found |-> out_q.scan_done && out_q.success)
    else $error("found without done or success");

  // a word moved to the output is shown in the next cycle
  a_advance_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("advanced word not shown");
`endif

endmodule

`default_nettype wire

// ----- bench/stream_substring_scanner_tb.sv -----
// self-checking bench for stream_substring_scanner: directed and random scans
// depends on sss_pkg and the stream_substring_scanner rtl only
`timescale 1ns / 1ps

module stream_substring_scanner_tb;

  localparam int unsigned MAX_PAT     = 32;
  localparam int unsigned HOLD_CYCLES = 150;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // block ports
  logic                         clk_i;
  logic                         rst_ni      = 1'b0;
  logic                         in_valid_i  = 1'b0;
  logic                         in_ready_o;
  sss_pkg::in_t                 in_item_i   = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  sss_pkg::out_t                out_item_o;
  logic                         cfg_we_i    = 1'b0;
  logic [sss_pkg::CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [sss_pkg::RegW-1:0]     cfg_wdata_i = '0;

  // predictor state, mirrors the block after reset
  logic [8*sss_pkg::PatBytes-1:0] pat_bits   = '0;
  logic [sss_pkg::LenW-1:0]       pat_len    = 6'd1;
  logic                           opt_mode   = 1'b0;
  logic [MAX_PAT-1:0]             prefix_vec = '0;
  logic [sss_pkg::CntW-1:0]       byte_cnt   = '0;

  sss_pkg::out_t pending[$];
  int unsigned mismatches     = 0;
  int unsigned words_sent     = 0;
  int unsigned eos_sent       = 0;
  int unsigned hits           = 0;
  int unsigned settings_count = 0;
  int unsigned cycles         = 0;
  bit          idle_on        = 1'b1;

  // receiver hold-off request and its own counter
  bit          hold_req  = 1'b0;
  bit          hold_seen = 1'b0;
  int unsigned hold_left = 0;

  stream_substring_scanner #(
    .MAX_PATTERN(MAX_PAT)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // 12 ns clock
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // pattern length in use: zero counts as one, overlong clips to the maximum
  function automatic int unsigned active_len(input logic [sss_pkg::LenW-1:0] code);
    if (code == '0) return 1;
    if (code > MAX_PAT) return MAX_PAT;
    return 32'(code);
  endfunction

  // shift-and update for one accepted word, returns the expected result
  function automatic sss_pkg::out_t scan_step(input sss_pkg::in_t w);
    sss_pkg::out_t      r;
    logic [MAX_PAT-1:0] eq;
    logic [MAX_PAT-1:0] nxt;
    int unsigned        n;
    r = '0;
    if (w.operation == sss_pkg::OP_EOS) begin
      r.scan_done      = 1'b1;
      r.success        = opt_mode;
      r.consumed_count = byte_cnt;
      prefix_vec       = '0;
      byte_cnt         = '0;
    end else begin
      n  = active_len(pat_len);
      eq = '0;
      for (int i = 0; i < n; i++) eq[i] = (pat_bits[i*8 +: 8] == w.data_byte);
      nxt = {prefix_vec[MAX_PAT-2:0], 1'b1} & eq;
      // count saturates
      if (byte_cnt != '1) byte_cnt++;
      r.consumed_count = byte_cnt;
      if (nxt[n-1]) begin
        r.scan_done = 1'b1;
        r.found     = 1'b1;
        r.success   = 1'b1;
        prefix_vec  = '0;
        byte_cnt    = '0;
      end else begin
        prefix_vec = nxt;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
  endtask

  // offer one word, idling now and then, and predict it once accepted
  task automatic send_word(input sss_pkg::op_e op, input logic [7:0] b);
    sss_pkg::in_t w;
    int unsigned  gap;
    w.operation = op;
    w.data_byte = b;
    if (idle_on && $urandom_range(99) < 12) begin
      in_valid_i <= 1'b0;
      gap = $urandom_range(1, 5);
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending = {pending, scan_step(w)};
    words_sent++;
    if (op == sss_pkg::OP_EOS) eos_sent++;
  endtask

  // sender pause until every result is back, then an idle wait
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input sss_pkg::cfg_idx_e idx,
                           input logic [sss_pkg::RegW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  // write all registers back to back while the block is idle
  task automatic load_config(input logic [8*sss_pkg::PatBytes-1:0] pat,
                             input logic [sss_pkg::LenW-1:0] len, input logic opt);
    settle();
    cfg_write(sss_pkg::REG_PAT_LOW,    pat[63:0]);
    cfg_write(sss_pkg::REG_PAT_SECOND, pat[127:64]);
    cfg_write(sss_pkg::REG_PAT_THIRD,  pat[191:128]);
    cfg_write(sss_pkg::REG_PAT_HIGH,   pat[255:192]);
    cfg_write(sss_pkg::REG_PAT_LEN,    sss_pkg::RegW'(len));
    cfg_write(sss_pkg::REG_OPT_MODE,   sss_pkg::RegW'(opt));
    cfg_we_i <= 1'b0;
    pat_bits = pat;
    pat_len  = len;
    opt_mode = opt;
    settings_count++;
  endtask

  // one scan: noise, then the pattern, an end of stream or random bytes
  task automatic send_scan(input logic [8*sss_pkg::PatBytes-1:0] pat, input int unsigned n);
    int unsigned noise;
    int unsigned kind;
    int unsigned pos;
    noise = $urandom_range(6);
    for (int k = 0; k < noise; k++) begin
      pos = $urandom_range(n - 1);
      if ($urandom_range(9) < 6) send_word(sss_pkg::OP_DATA, pat[pos*8 +: 8]);
      else send_word(sss_pkg::OP_DATA, 8'($urandom));
    end
    kind = $urandom_range(99);
    if (kind < 70) begin
      for (int k = 0; k < n; k++) send_word(sss_pkg::OP_DATA, pat[k*8 +: 8]);
    end else if (kind < 88) begin
      send_word(sss_pkg::OP_EOS, 8'($urandom));
    end else begin
      noise = $urandom_range(1, 12);
      for (int k = 0; k < noise; k++) send_word(sss_pkg::OP_DATA, 8'($urandom));
      if ($urandom_range(1)) send_word(sss_pkg::OP_EOS, 8'($urandom));
    end
  endtask

  // reset values: length one, pattern byte zero, optional mode off
  task automatic test_reset_defaults();
    send_word(sss_pkg::OP_DATA, 8'hFF);
    send_word(sss_pkg::OP_DATA, 8'h00);
    send_word(sss_pkg::OP_DATA, 8'h80);
    send_word(sss_pkg::OP_EOS,  8'h00);
    send_word(sss_pkg::OP_EOS,  8'hFF);
  endtask

  // overlapping prefixes, zero length and overlong length
  task automatic test_directed_patterns();
    logic [8*sss_pkg::PatBytes-1:0] pat;
    pat        = '0;
    pat[7:0]   = 8'h61;
    pat[15:8]  = 8'h62;
    pat[23:16] = 8'h61;
    load_config(pat, 6'd3, 1'b1);
    send_word(sss_pkg::OP_DATA, 8'h61);
    send_word(sss_pkg::OP_DATA, 8'h61);
    send_word(sss_pkg::OP_DATA, 8'h62);
    send_word(sss_pkg::OP_DATA, 8'h61);
    send_word(sss_pkg::OP_DATA, 8'h62);
    send_word(sss_pkg::OP_EOS,  8'h61);

    // zero length behaves as one byte
    pat      = '0;
    pat[7:0] = 8'h5A;
    load_config(pat, 6'd0, 1'b0);
    send_word(sss_pkg::OP_DATA, 8'hA5);
    send_word(sss_pkg::OP_DATA, 8'h5A);
    send_word(sss_pkg::OP_DATA, 8'hA5);
    send_word(sss_pkg::OP_EOS,  8'h00);

    // overlong length clips to the maximum, short run never completes
    load_config('0, 6'd63, 1'b0);
    send_word(sss_pkg::OP_DATA, 8'h00);
    send_word(sss_pkg::OP_DATA, 8'h00);
    send_word(sss_pkg::OP_DATA, 8'h00);
    send_word(sss_pkg::OP_EOS,  8'hFF);
  endtask

  // full 32-byte patterns: all ones, then random content
  task automatic test_full_length();
    logic [8*sss_pkg::PatBytes-1:0] pat;
    load_config('1, 6'd32, 1'b1);
    for (int k = 0; k < 40; k++) send_word(sss_pkg::OP_DATA, 8'hFF);
    send_word(sss_pkg::OP_EOS, 8'h00);
    for (int k = 0; k < 8; k++) pat[k*32 +: 32] = $urandom;
    load_config(pat, 6'd32, 1'b0);
    send_scan(pat, MAX_PAT);
    send_scan(pat, MAX_PAT);
    send_word(sss_pkg::OP_EOS, 8'h00);
  endtask

  // receiver holds off while the sender keeps offering, then a full drain
  task automatic test_back_pressure();
    logic [8*sss_pkg::PatBytes-1:0] pat;
    pat       = '0;
    pat[7:0]  = 8'h3C;
    pat[15:8] = 8'hC3;
    load_config(pat, 6'd2, 1'b1);
    idle_on  = 1'b0;
    hold_req <= ~hold_req;
    for (int k = 0; k < 60; k++) begin
      if (k % 15 == 14) send_word(sss_pkg::OP_EOS, 8'h00);
      else send_word(sss_pkg::OP_DATA, pat[$urandom_range(1)*8 +: 8]);
    end
    settle();
    for (int k = 0; k < 20; k++) send_word(sss_pkg::OP_DATA, pat[$urandom_range(1)*8 +: 8]);
    settle();
    idle_on = 1'b1;
  endtask

  // random register settings, each followed by a batch of scans
  task automatic test_random_scans(input int unsigned target);
    logic [8*sss_pkg::PatBytes-1:0] pat;
    logic [sss_pkg::LenW-1:0]       len;
    logic [7:0]                     syms [3];
    int unsigned                    pick;
    int unsigned                    mark;
    int unsigned                    phase_base;
    int unsigned                    phase;
    phase = 0;
    mark  = words_sent;
    while (words_sent - mark < target) begin
      // mostly short patterns, a few long, zero and overlong
      pick = $urandom_range(99);
      if (pick < 55) len = sss_pkg::LenW'($urandom_range(1, 6));
      else if (pick < 80) len = sss_pkg::LenW'($urandom_range(7, 16));
      else if (pick < 92) len = sss_pkg::LenW'($urandom_range(17, 32));
      else if (pick < 96) len = '0;
      else len = sss_pkg::LenW'($urandom_range(33, 63));
      // small alphabets give self-overlapping patterns
      for (int k = 0; k < 3; k++) syms[k] = 8'($urandom);
      pick = $urandom_range(2);
      for (int k = 0; k < sss_pkg::PatBytes; k++) begin
        if (pick == 0) pat[k*8 +: 8] = 8'($urandom);
        else pat[k*8 +: 8] = syms[$urandom_range(pick)];
      end
      load_config(pat, len, 1'($urandom_range(1)));
      idle_on    = (phase % 4 != 3);
      phase_base = words_sent;
      while (words_sent - phase_base < 80 && words_sent - mark < target)
        send_scan(pat, active_len(len));
      phase++;
    end
    idle_on = 1'b1;
  endtask

  // receiver: long hold-off on request, otherwise random stalls while idle_on is set
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen   <= hold_req;
      hold_left   <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (idle_on && $urandom_range(99) < 12) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // compare each result word with the oldest prediction
  always @(posedge clk_i) begin
    sss_pkg::out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending.size() == 0) begin
        report_mismatch("unexpected result word", out_item_o.consumed_count, '0);
      end else begin
        want = pending.pop_front();
        if (out_item_o.scan_done !== want.scan_done)
          report_mismatch("scan_done", 32'(out_item_o.scan_done), 32'(want.scan_done));
        if (out_item_o.found !== want.found)
          report_mismatch("found", 32'(out_item_o.found), 32'(want.found));
        if (out_item_o.success !== want.success)
          report_mismatch("success", 32'(out_item_o.success), 32'(want.success));
        if (out_item_o.consumed_count !== want.consumed_count)
          report_mismatch("consumed_count", out_item_o.consumed_count, want.consumed_count);
        if (want.found) hits++;
      end
    end
  end

  // test sequence
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_directed_patterns();
    test_full_length();
    test_back_pressure();
    test_random_scans(600);
    settle();
    if (pending.size() != 0) report_mismatch("results never returned", 32'(pending.size()), '0);
    $display("streamed %0d words (%0d end of stream) under %0d register settings",
             words_sent, eos_sent, settings_count);
    $display("%0d pattern hits seen, including a long output hold-off and sender drains", hits);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
